// ===== sv/vsc_pkg.sv =====
// Shared types, codes and constants of the vertex slot cache.
`default_nettype none

package vsc_pkg;

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 6;
  localparam int COORD_W = 16;
  localparam int POS_W   = 3 * COORD_W;
  localparam int ATTR_W  = 64;
  localparam int FOUND_W = 5;

  // Default cache depth and reset value of the usable size
  localparam int MAX_SLOTS_DEF = 32;
  localparam logic [SLOT_W-1:0] SLOTS_RESET = 6'd32;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_SET    = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // Status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  // Update request from the command stage to the position CAM
  typedef struct packed {
    logic              clear_all;
    logic              set_slot;
    logic              drop_slot;
    logic [SLOT_W-1:0] slot;
  } cam_upd_t;

endpackage

`default_nettype wire

// ===== sv/vsc_ifs.sv =====
// Handshake channel interfaces of the vertex slot cache.
`default_nettype none

interface vsc_cmd_if;
  import vsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [SLOT_W-1:0]         slot;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [ATTR_W-1:0]         vertex_attr;

  modport source (output valid, cmd, slot, pos_x, pos_y, pos_z, vertex_attr, input ready);
  modport sink   (input valid, cmd, slot, pos_x, pos_y, pos_z, vertex_attr, output ready);
endinterface

interface vsc_res_if;
  import vsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      hit;
  logic [FOUND_W-1:0]        found_slot;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [ATTR_W-1:0]         out_attr;

  modport source (output valid, status, hit, found_slot, out_x, out_y, out_z, out_attr,
                  input ready);
  modport sink   (input valid, status, hit, found_slot, out_x, out_y, out_z, out_attr,
                  output ready);
endinterface

interface vsc_cfg_if;
  import vsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slots_in_use;

  modport source (output valid, slots_in_use, input ready);
  modport sink   (input valid, slots_in_use, output ready);
endinterface

`default_nettype wire

// ===== sv/vsc_cam.sv =====
// Position CAM: per-slot position cells, mapped marks and parallel match.
`default_nettype none

module vsc_cam #(
  parameter int MAX_SLOTS = vsc_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire vsc_pkg::cam_upd_t            upd,
  input  wire logic [vsc_pkg::POS_W-1:0]    key,
  output logic                              hit,
  output logic [vsc_pkg::SLOT_W-1:0]        hit_slot,
  output logic [MAX_SLOTS-1:0]              map_vec
);
  import vsc_pkg::*;

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [POS_W-1:0]     pos_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] mapped_r;
  logic [MAX_SLOTS-1:0] mapped_nxt;
  logic [MAX_SLOTS-1:0] match;
  logic [IW-1:0]        idx;

  assign idx     = upd.slot[IW-1:0];
  assign map_vec = mapped_r;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      match[i] = mapped_r[i] && (pos_r[i] == key);
    end
  end

  // Lowest matching slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    mapped_nxt = mapped_r;
    if (upd.clear_all) begin
      mapped_nxt = '0;
    end else if (upd.set_slot) begin
      // take the mapping from any other holder of this position
      mapped_nxt      = mapped_r & ~match;
      mapped_nxt[idx] = 1'b1;
    end else if (upd.drop_slot) begin
      mapped_nxt[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_r <= '0;
    end else begin
      mapped_r <= mapped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (upd.set_slot && (idx == IW'(i))) begin
        pos_r[i] <= key;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/vertex_slot_cache_reverse_lookup.sv =====
// Vertex slot cache with reverse lookup by position: top level.
//
// Usage: commands arrive on in_chan (get, lookup, set, erase, clear), one
// transaction per command, and each command gives exactly one result
// transaction on out_chan. cfg_chan writes the usable slot count; write it
// only while the cache is idle. cfg_chan is always ready.
// Pipeline: an accepted command is registered in the command stage, evaluated
// into the result register, and offered on out_chan from then on.
// Throughput: one command per cycle while out_chan is ready. Lookup compares
// all slots at once in the position CAM; get reads the slot data memory on
// the accepting edge, with write-first bypass from a set leaving the command
// stage that cycle.
// Reset: all slots become invalid and unmapped, the usable size returns to
// 32. Position and attribute storage is not cleared; no unwritten entry is
// ever returned. No clearing pass, the block is ready right after reset.
// Stall: when out_chan is not ready the result register holds, the command
// stage holds behind it, and in_chan.ready drops once both are full.
`default_nettype none

module vertex_slot_cache_reverse_lookup #(
  parameter int MAX_SLOTS = vsc_pkg::MAX_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  vsc_cmd_if.sink   in_chan,
  vsc_res_if.source out_chan,
  vsc_cfg_if.sink   cfg_chan
);
  import vsc_pkg::*;

  localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int WORDW = ATTR_W + POS_W;
  localparam logic [SLOT_W:0] MAX_V = (SLOT_W + 1)'(MAX_SLOTS);

  // Configuration
  logic [SLOT_W-1:0] slots_r;
  logic [SLOT_W:0]   usable;

  // Command stage
  logic              s1_vld_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [ATTR_W-1:0] s1_attr_r;
  logic              s1_move;
  logic              in_acc;
  logic              in_range;
  logic              slot_cmd;
  logic              err;
  logic [IW-1:0]     s1_idx;

  // Slot data memory: {attr, position}
  logic [WORDW-1:0] mem [MAX_SLOTS];
  logic [WORDW-1:0] rd_r;
  logic [WORDW-1:0] wr_data;
  logic             wr_en;
  logic [IW-1:0]    rd_idx;
  logic             rd_ok;

  // Slot valid marks
  logic [MAX_SLOTS-1:0] valid_r;
  logic [MAX_SLOTS-1:0] valid_nxt;

  // CAM
  cam_upd_t             upd;
  logic                 cam_hit;
  logic [SLOT_W-1:0]    cam_slot;
  logic [MAX_SLOTS-1:0] map_vec;

  // Result register
  logic                      out_vld_r;
  logic                      status_r, status_nxt;
  logic                      hit_r, hit_nxt;
  logic [FOUND_W-1:0]        found_r, found_nxt;
  logic signed [COORD_W-1:0] x_r, x_nxt;
  logic signed [COORD_W-1:0] y_r, y_nxt;
  logic signed [COORD_W-1:0] z_r, z_nxt;
  logic [ATTR_W-1:0]         attr_r, attr_nxt;

  // Configuration port: always ready, clamp the size to the cache depth
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
    end else if (cfg_chan.valid) begin
      slots_r <= cfg_chan.slots_in_use;
    end
  end

  assign usable = ({1'b0, slots_r} > MAX_V) ? MAX_V : {1'b0, slots_r};

  // Handshake: the command stage advances whenever the result register frees
  assign s1_move       = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !s1_vld_r || s1_move;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_chan.cmd;
      s1_slot_r <= in_chan.slot;
      s1_pos_r  <= {in_chan.pos_z, in_chan.pos_y, in_chan.pos_x};
      s1_attr_r <= in_chan.vertex_attr;
    end
  end

  // Range check and decode in the command stage
  assign in_range = {1'b0, s1_slot_r} < usable;
  assign slot_cmd = (s1_cmd_r == CMD_GET) || (s1_cmd_r == CMD_SET) ||
                    (s1_cmd_r == CMD_ERASE);
  assign err      = slot_cmd && !in_range;
  assign s1_idx   = s1_slot_r[IW-1:0];

  // Memory: write from a set leaving the command stage, read on accept
  assign wr_en   = s1_move && (s1_cmd_r == CMD_SET) && in_range;
  assign wr_data = {s1_attr_r, s1_pos_r};
  assign rd_idx  = in_chan.slot[IW-1:0];
  assign rd_ok   = {1'b0, in_chan.slot} < MAX_V;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx] <= wr_data;
    end
    if (in_acc && rd_ok) begin
      // bypass the word being written this cycle
      if (wr_en && (s1_idx == rd_idx)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= mem[rd_idx];
      end
    end
  end

  // CAM update request, only when the command actually retires
  always_comb begin
    upd           = '0;
    upd.slot      = s1_slot_r;
    upd.clear_all = s1_move && (s1_cmd_r == CMD_CLEAR);
    upd.set_slot  = wr_en;
    upd.drop_slot = s1_move && (s1_cmd_r == CMD_ERASE) && in_range;
  end

  vsc_cam #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_cam (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .key      (s1_pos_r),
    .hit      (cam_hit),
    .hit_slot (cam_slot),
    .map_vec  (map_vec)
  );

  // Valid marks
  always_comb begin
    valid_nxt = valid_r;
    if (upd.clear_all) begin
      valid_nxt = '0;
    end else if (upd.set_slot) begin
      valid_nxt[s1_idx] = 1'b1;
    end else if (upd.drop_slot) begin
      valid_nxt[s1_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result formation
  always_comb begin
    status_nxt = err ? STAT_ERR : STAT_OK;
    hit_nxt    = 1'b0;
    found_nxt  = '0;
    x_nxt      = '0;
    y_nxt      = '0;
    z_nxt      = '0;
    attr_nxt   = '0;
    case (s1_cmd_r)
      CMD_GET: begin
        if (!err && valid_r[s1_idx]) begin
          hit_nxt  = 1'b1;
          x_nxt    = $signed(rd_r[COORD_W-1:0]);
          y_nxt    = $signed(rd_r[2*COORD_W-1:COORD_W]);
          z_nxt    = $signed(rd_r[POS_W-1:2*COORD_W]);
          attr_nxt = rd_r[WORDW-1:POS_W];
        end
      end
      CMD_LOOKUP: begin
        hit_nxt   = cam_hit;
        found_nxt = cam_slot[FOUND_W-1:0];
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_move) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      status_r <= status_nxt;
      hit_r    <= hit_nxt;
      found_r  <= found_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      z_r      <= z_nxt;
      attr_r   <= attr_nxt;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.status     = status_r;
  assign out_chan.hit        = hit_r;
  assign out_chan.found_slot = found_r;
  assign out_chan.out_x      = x_r;
  assign out_chan.out_y      = y_r;
  assign out_chan.out_z      = z_r;
  assign out_chan.out_attr   = attr_r;

`ifndef SYNTH
  // A mapped slot is always a valid slot
  a_mapped_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (map_vec & ~valid_r) == '0)
    else $error("mapped slot without valid mark");

  // A retiring clear empties both mark vectors
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (s1_cmd_r == CMD_CLEAR)) |=> (valid_r == '0) && (map_vec == '0))
    else $error("clear left marks behind");

  // A retiring in-range set leaves its slot valid and mapped
  a_set_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(s1_idx)] && map_vec[$past(s1_idx)])
    else $error("set slot not valid and mapped");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the vertex slot cache: directed and random commands, checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import vsc_pkg::*;

  localparam int NUM_SLOTS      = MAX_SLOTS_DEF;
  localparam int IDLE_PCT       = 8;     // chance per cycle that a side idles
  localparam int SETTLE_CYCLES  = 6;     // extra idle time after the last owed result
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction
  localparam int POOL_SIZE      = 8;

  // Commands above clear all are unused codes and must leave the cache alone
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_CLEAR + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  // Corner positions, packed z:y:x
  localparam logic [POS_W-1:0] POS_CORNER_A = {16'h0000, 16'h7FFF, 16'h8000};
  localparam logic [POS_W-1:0] POS_CORNER_B = {16'hFFFF, 16'h8000, 16'h7FFF};

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [ATTR_W-1:0]         attr;
  } cache_cmd_t;

  typedef struct packed {
    logic                      status;
    logic                      hit;
    logic [FOUND_W-1:0]        found_slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [ATTR_W-1:0]         attr;
  } cache_res_t;

  // Mirror of the cache contents; works out the result of every accepted command
  // and holds the results still owed by the block.
  class slot_cache_tracker;
    logic              slot_valid  [NUM_SLOTS];
    logic              slot_mapped [NUM_SLOTS];
    logic [POS_W-1:0]  slot_pos    [NUM_SLOTS];
    logic [ATTR_W-1:0] slot_attr   [NUM_SLOTS];
    logic [SLOT_W-1:0] slot_count;
    cache_res_t        owed_q[$];
    int unsigned       failures;

    function new();
      slot_count = SLOTS_RESET;
      failures   = 0;
      foreach (slot_valid[i]) begin
        slot_valid[i]  = 1'b0;
        slot_mapped[i] = 1'b0;
        slot_pos[i]    = '0;
        slot_attr[i]   = '0;
      end
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction

    function void note_command(cache_cmd_t c);
      cache_res_t       r;
      logic [POS_W-1:0] key;
      int unsigned      usable;
      int unsigned      idx;
      r      = '0;
      key    = {c.pos_z, c.pos_y, c.pos_x};
      usable = (slot_count > NUM_SLOTS) ? NUM_SLOTS : slot_count;
      idx    = c.slot % NUM_SLOTS;
      if ((c.cmd == CMD_GET || c.cmd == CMD_SET || c.cmd == CMD_ERASE) && c.slot >= usable) begin
        r.status = STAT_ERR;
      end else begin
        case (c.cmd)
          CMD_GET: begin
            if (slot_valid[idx]) begin
              r.hit               = 1'b1;
              {r.z, r.y, r.x}     = slot_pos[idx];
              r.attr              = slot_attr[idx];
            end
          end
          CMD_LOOKUP: begin
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
              if (slot_mapped[i] && slot_pos[i] == key) begin
                r.hit        = 1'b1;
                r.found_slot = FOUND_W'(i);
              end
            end
          end
          CMD_SET: begin
            // take the position's mapping away from whichever slot holds it
            foreach (slot_mapped[i])
              if (slot_mapped[i] && slot_pos[i] == key) slot_mapped[i] = 1'b0;
            slot_mapped[idx] = 1'b1;
            slot_valid[idx]  = 1'b1;
            slot_pos[idx]    = key;
            slot_attr[idx]   = c.attr;
          end
          CMD_ERASE: begin
            slot_mapped[idx] = 1'b0;
            slot_valid[idx]  = 1'b0;
          end
          CMD_CLEAR: begin
            foreach (slot_valid[i]) begin
              slot_valid[i]  = 1'b0;
              slot_mapped[i] = 1'b0;
            end
          end
          default: ;
        endcase
      end
      owed_q.push_back(r);
    endfunction

    function void compare_field(string tag, logic [ATTR_W-1:0] want, logic [ATTR_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
        failures++;
      end
    endfunction

    function void check_result(cache_res_t got);
      cache_res_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result transaction with nothing outstanding", $time);
        failures++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("hit", want.hit, got.hit);
      compare_field("found_slot", want.found_slot, got.found_slot);
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_z", want.z, got.z);
      compare_field("out_attr", want.attr, got.attr);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic steady_run;   // high while neither side may idle
  int   quiet_cycles;

  logic [POS_W-1:0] pos_pool [POOL_SIZE];

  slot_cache_tracker tracker = new();

  vsc_cmd_if in_if ();
  vsc_res_if out_if ();
  vsc_cfg_if cfg_if ();

  vertex_slot_cache_reverse_lookup #(
    .MAX_SLOTS (NUM_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #5 clk = ~clk;

  // Result side: drop ready now and then, except during the steady stretch.
  always @(posedge clk) begin
    if (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Check every result transaction against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      tracker.check_result({out_if.status, out_if.hit, out_if.found_slot,
                            out_if.out_x, out_if.out_y, out_if.out_z, out_if.out_attr});
    end
  end

  // Watchdog: give up once no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [POS_W-1:0] random_position();
    return {COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)};
  endfunction

  function automatic cache_cmd_t make_cmd(logic [CMD_W-1:0] op, logic [SLOT_W-1:0] slot,
                                          logic [POS_W-1:0] pos, logic [ATTR_W-1:0] attr);
    cache_cmd_t c;
    c.cmd                     = op;
    c.slot                    = slot;
    {c.pos_z, c.pos_y, c.pos_x} = pos;
    c.attr                    = attr;
    return c;
  endfunction

  // Build a random command. Most slots fall inside the usable span so that sets,
  // gets and erases do real work; most positions come from a small pool so that
  // lookups hit and sets steal mappings from one another.
  function automatic cache_cmd_t random_command(int unsigned span);
    int unsigned       pick;
    logic [CMD_W-1:0]  op;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    pick = $urandom_range(0, 99);
    if (pick < 25)      op = CMD_GET;
    else if (pick < 50) op = CMD_LOOKUP;
    else if (pick < 80) op = CMD_SET;
    else if (pick < 92) op = CMD_ERASE;
    else if (pick < 95) op = CMD_CLEAR;
    else                op = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    if ($urandom_range(0, 99) < 85) slot = SLOT_W'($urandom_range(0, span - 1));
    else                            slot = SLOT_W'($urandom);
    if ($urandom_range(0, 99) < 70) pos = pos_pool[$urandom_range(0, POOL_SIZE - 1)];
    else                            pos = random_position();
    return make_cmd(op, slot, pos, {$urandom, $urandom});
  endfunction

  // Present one command and hold it until the cache takes it. Valid stays high
  // afterwards so back-to-back commands need no second assignment in one step.
  task automatic send_command(input cache_cmd_t c);
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= c.cmd;
    in_if.slot        <= c.slot;
    in_if.pos_x       <= c.pos_x;
    in_if.pos_y       <= c.pos_y;
    in_if.pos_z       <= c.pos_z;
    in_if.vertex_attr <= c.attr;
    do @(posedge clk); while (!in_if.ready);
    tracker.note_command(c);
  endtask

  // Stop sending, wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the usable slot count; only called with the cache idle.
  task automatic write_slot_count(input logic [SLOT_W-1:0] n);
    drain_results();
    cfg_if.valid        <= 1'b1;
    cfg_if.slots_in_use <= n;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid       <= 1'b0;
    tracker.slot_count  = n;
  endtask

  initial begin
    cache_cmd_t        directed[$];
    logic [SLOT_W-1:0] phase_size [6];
    int                phase_len  [6];
    int unsigned       span;
    int                ph;
    int                k;

    // Known values on every input from time zero, with reset asserted first.
    rst_n               = 1'b0;
    steady_run          = 1'b0;
    quiet_cycles        = 0;
    in_if.valid         = 1'b0;
    in_if.cmd           = '0;
    in_if.slot          = '0;
    in_if.pos_x         = '0;
    in_if.pos_y         = '0;
    in_if.pos_z         = '0;
    in_if.vertex_attr   = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.slots_in_use = '0;

    pos_pool[0] = POS_CORNER_A;
    pos_pool[1] = POS_CORNER_B;
    pos_pool[2] = '0;
    pos_pool[3] = '1;
    for (k = 4; k < POOL_SIZE; k++) pos_pool[k] = random_position();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size: mapping moves between slots, erase of a
    // slot that no longer holds the mapping, out-of-range slots, unused codes,
    // re-setting a slot with its own position, and clear all.
    directed.push_back(make_cmd(CMD_GET,    6'd0,  '0,           '0));
    directed.push_back(make_cmd(CMD_LOOKUP, 6'd0,  POS_CORNER_A, '0));
    directed.push_back(make_cmd(CMD_SET,    6'd0,  POS_CORNER_A, '1));
    directed.push_back(make_cmd(CMD_GET,    6'd0,  '0,           '0));
    directed.push_back(make_cmd(CMD_LOOKUP, 6'd0,  POS_CORNER_A, '0));
    directed.push_back(make_cmd(CMD_SET,    6'd31, POS_CORNER_A, '0));
    directed.push_back(make_cmd(CMD_LOOKUP, 6'd0,  POS_CORNER_A, '0));
    directed.push_back(make_cmd(CMD_GET,    6'd0,  '0,           '0));
    directed.push_back(make_cmd(CMD_ERASE,  6'd0,  '0,           '0));
    directed.push_back(make_cmd(CMD_LOOKUP, 6'd0,  POS_CORNER_A, '0));
    directed.push_back(make_cmd(CMD_ERASE,  6'd31, '0,           '0));
    directed.push_back(make_cmd(CMD_LOOKUP, 6'd0,  POS_CORNER_A, '0));
    directed.push_back(make_cmd(CMD_GET,    6'd31, '0,           '0));
    directed.push_back(make_cmd(CMD_GET,    6'd32, '0,           '0));
    directed.push_back(make_cmd(CMD_SET,    6'd63, POS_CORNER_B, '1));
    directed.push_back(make_cmd(CMD_ERASE,  6'd40, '0,           '0));
    directed.push_back(make_cmd(CMD_SET,    6'd5,  POS_CORNER_B, 64'h8000_0000_0000_0001));
    directed.push_back(make_cmd(CMD_SET,    6'd5,  POS_CORNER_B, '1));
    directed.push_back(make_cmd(CMD_LOOKUP, 6'd63, POS_CORNER_B, '0));
    directed.push_back(make_cmd(CMD_UNUSED_LO, 6'd5, POS_CORNER_B, '1));
    directed.push_back(make_cmd(CMD_UNUSED_HI, '1,   '1,           '1));
    directed.push_back(make_cmd(CMD_CLEAR,  6'd0,  '0,           '0));
    directed.push_back(make_cmd(CMD_GET,    6'd5,  '0,           '0));
    directed.push_back(make_cmd(CMD_LOOKUP, 6'd0,  POS_CORNER_B, '0));
    directed.push_back(make_cmd(CMD_SET,    6'd6,  POS_CORNER_A, 64'h0123_4567_89AB_CDEF));
    foreach (directed[i]) send_command(directed[i]);

    // Random phases, each at its own usable size: a single slot, no slots at all,
    // a size above the cache depth, two middle sizes and back to the full cache.
    // Slots mapped earlier stay visible to lookup when the size shrinks.
    phase_size = '{6'd1, 6'd0, 6'd63, 6'd17, SLOT_W'($urandom_range(2, NUM_SLOTS - 1)), 6'd32};
    phase_len  = '{150, 60, 300, 240, 240, 240};
    for (ph = 0; ph < 6; ph++) begin
      write_slot_count(phase_size[ph]);
      span = (phase_size[ph] > NUM_SLOTS) ? NUM_SLOTS : phase_size[ph];
      if (span == 0) span = 1;
      for (k = 0; k < phase_len[ph]; k++) begin
        // hold both sides busy through a long stretch of the deep-size phase
        if (ph == 2 && k == 50)  steady_run <= 1'b1;
        if (ph == 2 && k == 250) steady_run <= 1'b0;
        send_command(random_command(span));
      end
    end

    drain_results();
    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/vsc_pkg.sv
sv/vsc_ifs.sv
sv/vsc_cam.sv
sv/vertex_slot_cache_reverse_lookup.sv
tb/tb.sv
